FILE: src/tcbos_pkg.sv
// ----------------------------------------------------------------------------
// tcbos_pkg: shared types and constants for the two-class burst scheduler
// Store geometry, field widths, the store write request and the ALU request
// and response types.
// ----------------------------------------------------------------------------
package tcbos_pkg;

    localparam int MAX_PROCS = 64;
    // Capacity is bounded by the 6-bit process number.
    localparam int STORE_CAP = (MAX_PROCS < 64) ? MAX_PROCS : 64;
    localparam int ADDR_W    = $clog2(STORE_CAP);
    localparam int CNT_W     = $clog2(STORE_CAP + 1);

    localparam int BURST_W   = 16;
    localparam int IDX_W     = 6;
    localparam int TIME_W    = 22;
    localparam int WTOT_W    = 27;
    localparam int TTOT_W    = 28;
    localparam int KEY_W     = BURST_W + 1;
    localparam int ALU_W     = 28;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 128;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               cls;
        logic [BURST_W-1:0] burst;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_wr_req;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

endpackage

FILE: src/tcbos_store.sv
// ----------------------------------------------------------------------------
// tcbos_store: sorted process store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcbos_store (
    input  logic                       i_clk,
    input  tcbos_pkg::t_wr_req         i_wr,
    input  logic [tcbos_pkg::ADDR_W-1:0] i_rd_addr,
    output tcbos_pkg::t_entry          o_rd_data
);
    import tcbos_pkg::*;

    t_entry r_mem [STORE_CAP];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

FILE: src/tcbos_alu.sv
// ----------------------------------------------------------------------------
// tcbos_alu: shared adder / subtractor
// Serves the key compare during insertion and all time sums during output.
// ----------------------------------------------------------------------------
module tcbos_alu (
    input  tcbos_pkg::t_alu_req i_req,
    output tcbos_pkg::t_alu_rsp o_rsp
);
    import tcbos_pkg::*;

    logic [ALU_W:0]   w_sum;
    logic [ALU_W-1:0] w_b;
    logic             w_cin;

    always_comb begin
        unique case (i_req.op)
            ALU_SUB: begin
                w_b   = ~i_req.b;
                w_cin = 1'b1;
            end
            default: begin
                w_b   = i_req.b;
                w_cin = 1'b0;
            end
        endcase
        w_sum = {1'b0, i_req.a} + {1'b0, w_b} + (ALU_W + 1)'(w_cin);
        o_rsp.res    = w_sum[ALU_W-1:0];
        // borrow: a < b on a subtract
        o_rsp.borrow = w_cin & ~w_sum[ALU_W];
    end

endmodule

FILE: src/two_class_burst_order_schedule_unit.sv
// Insertion walks the filled store one entry per cycle from the top, shifting up
//   entries that go after the new word, then writes it into the hole.
// A last word then streams the results; each passes the read, load, sum and send states plus any output stall.
// Throughput: one word at a time; s_tready is high only while idle.
// Reset: synchronous active-low i_rst_n clears the sequencer, entry count and
//   overflow flag; store contents are left as they are.
// ----------------------------------------------------------------------------
// two_class_burst_order_schedule_unit: two-class burst-order scheduler
// Keeps a stably sorted store of process descriptors and, on the word marked
// last, streams them out in schedule order with waiting and turnaround times.
// ----------------------------------------------------------------------------
module two_class_burst_order_schedule_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcbos_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] burst_time
    input  logic [0:0]                        s_tuser,  // [0] is_user
    input  logic                              s_tlast,  // last_item
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [5:0] process_index, [21:6] burst_out, [43:22] waiting_time,
    // [65:44] turnaround_time, [92:66] wait_total, [120:93] turnaround_total,
    // [127:121] zero
    output logic [tcbos_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [tcbos_pkg::M_TUSER_W-1:0]   m_tuser,  // [0] class_out, [1] dropped
    output logic                              m_tlast   // last_result
);
    import tcbos_pkg::*;

    localparam int OUT_PAD = M_TDATA_W - (IDX_W + BURST_W + 2 * TIME_W + WTOT_W + TTOT_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,     // first store read in flight
        S_INS_CMP,    // compare entry k, shift it up if it goes after
        S_INS_PUT,    // write the new entry into the hole
        S_OUT_RD,     // read entry k
        S_OUT_LOAD,   // turnaround = wait + burst
        S_OUT_WSUM,   // running wait total
        S_OUT_TSUM,   // running turnaround total, load output word
        S_OUT_SEND    // hold the output word until taken
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [ADDR_W-1:0]  r_k;
    logic [ADDR_W-1:0]  r_pos;
    logic [BURST_W-1:0] r_b;
    logic               r_c;
    logic               r_last;

    // output-side payload
    t_entry             r_cur;
    logic [TIME_W-1:0]  r_wait;
    logic [TIME_W-1:0]  r_turn;
    logic [WTOT_W-1:0]  r_wsum;
    logic [TTOT_W-1:0]  r_tsum;
    logic [WTOT_W-1:0]  r_wtot;
    logic [TTOT_W-1:0]  r_ttot;
    logic               r_out_last;

    t_wr_req            w_wr;
    logic [ADDR_W-1:0]  w_rd_addr;
    t_entry             w_rd_data;
    t_alu_req           w_alu_req;
    t_alu_rsp           w_alu_rsp;
    t_entry             w_new;
    logic [KEY_W-1:0]   w_key_new;
    logic [KEY_W-1:0]   w_key_k;
    logic               w_after;
    logic               w_is_last_k;
    logic               w_s_acc;
    logic               w_m_acc;

    tcbos_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tcbos_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = (r_state == S_OUT_SEND);
    assign w_s_acc  = s_tvalid & s_tready;
    assign w_m_acc  = m_tvalid & m_tready;

    assign m_tdata = {{OUT_PAD{1'b0}}, r_ttot, r_wtot, r_turn, r_wait, r_cur.burst, r_cur.idx};
    assign m_tuser = {r_ovf, r_cur.cls};
    assign m_tlast = r_out_last;

    // Sort key: class first, then longer burst first. A stored entry goes
    // after the new one only when its key is strictly larger, so ties keep
    // arrival order.
    assign w_key_new = {r_c, ~r_b};
    assign w_key_k   = {w_rd_data.cls, ~w_rd_data.burst};
    assign w_after   = w_alu_rsp.borrow;

    assign w_new.idx   = IDX_W'(r_count);
    assign w_new.cls   = r_c;
    assign w_new.burst = r_b;

    assign w_is_last_k = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);

    // read address: during the compare walk, fetch the next entry down
    assign w_rd_addr = (r_state == S_INS_CMP) ? (r_k - ADDR_W'(1)) : r_k;

    always_comb begin
        w_wr.en   = 1'b0;
        w_wr.addr = r_pos;
        w_wr.data = w_new;
        if (r_state == S_INS_CMP && w_after) begin
            w_wr.en   = 1'b1;
            w_wr.addr = r_k + ADDR_W'(1);
            w_wr.data = w_rd_data;
        end else if (r_state == S_INS_PUT) begin
            w_wr.en = 1'b1;
        end
    end

    // shared adder operand select
    always_comb begin
        w_alu_req.op = ALU_ADD;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        unique case (r_state)
            S_INS_CMP: begin
                w_alu_req.op = ALU_SUB;
                w_alu_req.a  = ALU_W'(w_key_new);
                w_alu_req.b  = ALU_W'(w_key_k);
            end
            S_OUT_LOAD: begin
                w_alu_req.a = ALU_W'(r_wait);
                w_alu_req.b = ALU_W'(w_rd_data.burst);
            end
            S_OUT_WSUM: begin
                w_alu_req.a = ALU_W'(r_wsum);
                w_alu_req.b = ALU_W'(r_wait);
            end
            S_OUT_TSUM: begin
                w_alu_req.a = ALU_W'(r_tsum);
                w_alu_req.b = ALU_W'(r_turn);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_b    <= s_tdata[BURST_W-1:0];
                        r_c    <= s_tuser[0];
                        r_last <= s_tlast;
                        if (r_count < CNT_W'(STORE_CAP)) begin
                            if (r_count == '0) begin
                                r_pos   <= '0;
                                r_state <= S_INS_PUT;
                            end else begin
                                r_k     <= ADDR_W'(r_count - CNT_W'(1));
                                r_state <= S_INS_RD;
                            end
                        end else begin
                            // store full: drop, but a last word still starts the run
                            r_ovf <= 1'b1;
                            if (s_tlast) begin
                                r_k     <= '0;
                                r_wait  <= '0;
                                r_wsum  <= '0;
                                r_tsum  <= '0;
                                r_state <= S_OUT_RD;
                            end
                        end
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_CMP;
                end
                S_INS_CMP: begin
                    if (w_after) begin
                        if (r_k == '0) begin
                            r_pos   <= '0;
                            r_state <= S_INS_PUT;
                        end else begin
                            r_k <= r_k - ADDR_W'(1);
                        end
                    end else begin
                        r_pos   <= r_k + ADDR_W'(1);
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    r_count <= r_count + CNT_W'(1);
                    if (r_last) begin
                        r_k     <= '0;
                        r_wait  <= '0;
                        r_wsum  <= '0;
                        r_tsum  <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_OUT_RD: begin
                    r_state <= S_OUT_LOAD;
                end
                S_OUT_LOAD: begin
                    r_cur   <= w_rd_data;
                    r_turn  <= TIME_W'(w_alu_rsp.res);
                    r_state <= S_OUT_WSUM;
                end
                S_OUT_WSUM: begin
                    r_wsum  <= WTOT_W'(w_alu_rsp.res);
                    r_state <= S_OUT_TSUM;
                end
                S_OUT_TSUM: begin
                    r_tsum     <= TTOT_W'(w_alu_rsp.res);
                    r_out_last <= w_is_last_k;
                    r_wtot     <= w_is_last_k ? r_wsum : '0;
                    r_ttot     <= w_is_last_k ? TTOT_W'(w_alu_rsp.res) : '0;
                    r_state    <= S_OUT_SEND;
                end
                S_OUT_SEND: begin
                    if (w_m_acc) begin
                        r_wait <= r_turn;
                        if (r_out_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + ADDR_W'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // entry count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_CAP))
        else $error("entry count above capacity");

    // the compare walk stays inside the filled part of the store
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (CNT_W'(r_k) < r_count))
        else $error("insertion walk outside filled entries");

    // the input side is closed while a result is pending
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !s_tready)
        else $error("input open while result pending");

    // the final result empties the store and clears the drop flag
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m_acc && m_tlast) |=> (r_count == '0 && !r_ovf && s_tready))
        else $error("run end did not clear state");

    // totals are zero on every result but the final one
    a_tot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tlast) |-> (r_wtot == '0 && r_ttot == '0))
        else $error("totals nonzero before final result");
`endif

endmodule

FILE: test/tb_two_class_burst_order_schedule_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_class_burst_order_schedule_unit: self-checking bench for the scheduler
// Loads process sets through the input stream and checks every result word
// against a behavioral scheduler kept in the bench: class order, stable
// longest-burst-first order, waiting and turnaround times, totals on the
// last word and the dropped flag once the store overflows.
// ----------------------------------------------------------------------------
module tb_two_class_burst_order_schedule_unit;

    import tcbos_pkg::*;

    localparam int QUIET_LIMIT = 3000;  // cycles without any handshake
    localparam int RX_HOLD     = 400;   // long output stall for the output-hold test
    localparam int N_ITEMS     = 460;

    // one expected result word
    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic               cls;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  wait_t;
        logic [TIME_W-1:0]  turn_t;
        logic               last;
        logic [WTOT_W-1:0]  wait_sum;
        logic [TTOT_W-1:0]  turn_sum;
        logic               dropped;
    } t_sched_word;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // [15:0] burst_time
    logic [0:0]             s_tuser  = '0;  // [0] is_user
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [5:0] process_index, [21:6] burst_out, [43:22] waiting_time,
    // [65:44] turnaround_time, [92:66] wait_total, [120:93] turnaround_total
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;        // [0] class_out, [1] dropped
    logic                   m_tlast;

    // bench copy of the sorted store and the pending results
    t_entry      run_queue[$];
    logic        run_dropped = 1'b0;
    t_sched_word sched_expect[$];

    int   errors        = 0;
    int   items_sent    = 0;
    int   quiet_cycles  = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    logic tx_idle_en    = 1'b1;
    logic rx_idle_en    = 1'b1;

    two_class_burst_order_schedule_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scheduler model
    // ------------------------------------------------------------------

    // Stored entry e is scheduled behind a new process (cls, burst):
    // user behind system, then shorter burst behind longer. Ties stay put.
    function automatic logic sched_behind(t_entry e, logic cls, logic [BURST_W-1:0] burst);
        if (e.cls != cls)
            return e.cls > cls;
        return e.burst < burst;
    endfunction

    // Dump the whole set in schedule order and start a fresh one.
    task automatic release_schedule();
        longint wait_acc;
        longint turn;
        longint wsum;
        longint tsum;
        t_sched_word w;
        wait_acc = 0;
        wsum     = 0;
        tsum     = 0;
        for (int k = 0; k < run_queue.size(); k++) begin
            turn = wait_acc + run_queue[k].burst;
            wsum += wait_acc;
            tsum += turn;
            w.idx      = run_queue[k].idx;
            w.cls      = run_queue[k].cls;
            w.burst    = run_queue[k].burst;
            w.wait_t   = TIME_W'(wait_acc);
            w.turn_t   = TIME_W'(turn);
            w.last     = (k == run_queue.size() - 1);
            w.wait_sum = w.last ? WTOT_W'(wsum) : '0;
            w.turn_sum = w.last ? TTOT_W'(tsum) : '0;
            w.dropped  = run_dropped;
            sched_expect.push_back(w);
            wait_acc = turn;
        end
        run_queue.delete();
        run_dropped = 1'b0;
    endtask

    // Book one accepted process word into the model.
    task automatic book_process(logic [BURST_W-1:0] burst, logic cls, logic last);
        int     pos;
        t_entry e;
        if (run_queue.size() < STORE_CAP) begin
            pos = 0;
            while (pos < run_queue.size() && !sched_behind(run_queue[pos], cls, burst))
                pos++;
            e.idx   = IDX_W'(run_queue.size());
            e.cls   = cls;
            e.burst = burst;
            run_queue.insert(pos, e);
        end else begin
            run_dropped = 1'b1;
        end
        if (last)
            release_schedule();
    endtask

    // ------------------------------------------------------------------
    // Input side: one word per call, returns at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_process(logic [BURST_W-1:0] burst, logic cls, logic last);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= burst;
        s_tuser  <= cls;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        book_process(burst, cls, last);
        items_sent++;
    endtask

    // burst values biased toward ties and the range ends
    function automatic logic [BURST_W-1:0] pick_burst();
        case ($urandom_range(0, 7))
            0, 1:    return BURST_W'($urandom_range(0, 3));
            2:       return $urandom_range(0, 1) ? '1 : '0;
            default: return BURST_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: random pauses after each word, long hold on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int pause;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD) @(posedge i_clk);
                hold_served++;
            end else if (m_tready && m_tvalid) begin
                pause = rx_idle_en ? $urandom_range(0, 8) : 0;
                if (pause != 0) begin
                    m_tready <= 1'b0;
                    repeat (pause) @(posedge i_clk);
                end
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sched_word w;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (sched_expect.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                w = sched_expect.pop_front();
                check_field("process_index",    w.idx,      m_tdata[5:0]);
                check_field("class_out",        w.cls,      m_tuser[0]);
                check_field("burst_out",        w.burst,    m_tdata[21:6]);
                check_field("waiting_time",     w.wait_t,   m_tdata[43:22]);
                check_field("turnaround_time",  w.turn_t,   m_tdata[65:44]);
                check_field("last_result",      w.last,     m_tlast);
                check_field("wait_total",       w.wait_sum, m_tdata[92:66]);
                check_field("turnaround_total", w.turn_sum, m_tdata[120:93]);
                check_field("dropped",          w.dropped,  m_tuser[1]);
            end
        end
    end

    // watchdog: any handshake resets the quiet count
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // one-process sets at both burst extremes and both classes
    task automatic test_single_sets();
        send_process('0, 1'b0, 1'b1);
        send_process('1, 1'b1, 1'b1);
        send_process('1, 1'b0, 1'b1);
    endtask

    // system ahead of user, longer burst first, extremes mixed in
    task automatic test_class_order();
        send_process(16'd10,    1'b1, 1'b0);
        send_process(16'd5,     1'b0, 1'b0);
        send_process('1,        1'b1, 1'b0);
        send_process('1,        1'b0, 1'b0);
        send_process('0,        1'b0, 1'b0);
        send_process(16'h8000,  1'b1, 1'b0);
        send_process(16'h7FFF,  1'b0, 1'b0);
        send_process('0,        1'b1, 1'b1);
    endtask

    // equal keys must come out in arrival order
    task automatic test_equal_keys();
        send_process(16'd7, 1'b0, 1'b0);
        send_process(16'd7, 1'b1, 1'b0);
        send_process(16'd7, 1'b0, 1'b0);
        send_process(16'd7, 1'b1, 1'b0);
        send_process(16'd9, 1'b1, 1'b0);
        send_process(16'd7, 1'b0, 1'b1);
    endtask

    // store fills: extra words are dropped, a last word on a full store
    // still fires the run; all-max bursts drive the totals to their top
    task automatic test_overflow();
        for (int k = 0; k < STORE_CAP + 2; k++)
            send_process('1, 1'(($urandom_range(0, 1))), k == STORE_CAP + 1);
        // exactly full, no drop
        for (int k = 0; k < STORE_CAP; k++)
            send_process(pick_burst(), 1'($urandom_range(0, 1)), k == STORE_CAP - 1);
    endtask

    // output held long while the next set keeps being offered
    task automatic test_output_hold();
        @(negedge i_clk);
        hold_requests++;
        @(posedge i_clk);
        for (int k = 0; k < 8; k++)
            send_process(pick_burst(), 1'($urandom_range(0, 1)), k == 7);
        for (int k = 0; k < 5; k++)
            send_process(pick_burst(), 1'($urandom_range(0, 1)), k == 4);
    endtask

    // random sets, mostly small, now and then full or overflowing
    task automatic test_random_sets();
        int set_len;
        int sel;
        while (items_sent < N_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                set_len = $urandom_range(STORE_CAP - 2, STORE_CAP + 4);
            else if (sel < 4)
                set_len = $urandom_range(13, 30);
            else
                set_len = $urandom_range(1, 12);
            // some sets run at full rate on both sides
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < set_len; k++)
                send_process(pick_burst(), 1'($urandom_range(0, 1)), k == set_len - 1);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_sets();
        test_class_order();
        test_equal_keys();
        test_overflow();
        test_output_hold();
        test_random_sets();
        s_tvalid <= 1'b0;

        while (sched_expect.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/tcbos_pkg.sv
src/tcbos_store.sv
src/tcbos_alu.sv
src/two_class_burst_order_schedule_unit.sv
test/tb_two_class_burst_order_schedule_unit.sv
